// ===== hdl/two_class_priority_fifo_top_defines.svh =====
// Assertion macros shared by the two-class priority FIFO RTL.
// Needs nothing else; take it in with an include by bare file name.
`ifndef TWO_CLASS_PRIORITY_FIFO_TOP_DEFINES_SVH
`define TWO_CLASS_PRIORITY_FIFO_TOP_DEFINES_SVH

// Same-cycle implication under the active-low reset.
`define TCPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the active-low reset.
`define TCPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tcpf_pkg.sv =====
// Types and constants of the two-class priority FIFO.
// Used by the controller, the datapath and the top level; depends on nothing.
package tcpf_pkg;

    localparam int KEY_W     = 8;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 3;

    localparam logic [KEY_W-1:0] THRESHOLD_RESET = 8'd60;

    // operation selector on the slave side
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED_PRIO = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SERVED_NORM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic                push_prio;
        logic                push_norm;
        logic                pop_prio;
        logic                pop_norm;
        logic                res_load;
        logic                res_from_ram;
        logic [STATUS_W-1:0] res_status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cls_prio;
        logic prio_full;
        logic norm_full;
        logic prio_any;
        logic norm_any;
        logic skid_full;
    } t_sts;

endpackage

// ===== hdl/two_class_priority_fifo_top.sv =====
// Two-class priority FIFO: an insert or empty serve is registered as its result on
// acceptance; a serve that returns an entry first passes the registered store read.
// Throughput: one insert per cycle while the skid stage is empty; a serve that
// returns an entry holds the controller in its read state for the store read.
// Reset (i_rst_n low, synchronous): both queues empty, threshold 60, output empty.
// Store contents are not cleared; entries are read only after being written.
module two_class_priority_fifo_top
    import tcpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int TAG_BITS    = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: priority threshold
    input  logic                           i_cfg_we,
    input  logic [KEY_W-1:0]               i_cfg_wdata,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [KEY_W+PAYLOAD_W-1:0]     s_axis_tdata,  // [7:0] key_value, [39:8] payload_tag
    input  logic                           s_axis_tuser,  // [0] op
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [KEY_W+PAYLOAD_W-1:0]     m_axis_tdata,  // [7:0] out_key, [39:8] out_payload
    output logic [STATUS_W-1:0]            m_axis_tuser   // [2:0] status
);

    t_cmd w_cmd;
    t_sts w_sts;

    logic [STATUS_W-1:0]  w_out_status;
    logic [KEY_W-1:0]     w_out_key;
    logic [PAYLOAD_W-1:0] w_out_payload;

    // Sequence each word: classify and push (or drop) on acceptance, or pop and
    // wait in the read state for the store read.
    tcpf_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .i_op   (s_axis_tuser),
        .o_ready(s_axis_tready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    // Hold the queues and the result word; the skid stage lets a new word
    // in while the previous result waits on the master side.
    tcpf_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_key        (s_axis_tdata[KEY_W-1:0]),
        .i_payload    (s_axis_tdata[KEY_W+PAYLOAD_W-1:KEY_W]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (w_out_status),
        .o_out_key    (w_out_key),
        .o_out_payload(w_out_payload)
    );

    assign m_axis_tdata = {w_out_payload, w_out_key};
    assign m_axis_tuser = w_out_status;

endmodule

// ===== hdl/tcpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module tcpf_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hdl/tcpf_ctrl.sv =====
// Controller of the two-class priority FIFO: input handshake and sequencing.
// Depends on tcpf_pkg; drives the datapath through t_cmd, reads t_sts.
module tcpf_ctrl
    import tcpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                r_state, n_state;
    logic [STATUS_W-1:0] r_rd_status, n_rd_status;
    logic                w_accept;

    assign o_ready  = i_rst_n && (r_state == S_IDLE) && !i_sts.skid_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_rd_status = r_rd_status;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_INSERT) begin
                        o_cmd.res_load = 1'b1;
                        if (i_sts.cls_prio) begin
                            o_cmd.push_prio  = !i_sts.prio_full;
                            o_cmd.res_status = i_sts.prio_full ? ST_DROPPED : ST_INSERTED;
                        end else begin
                            o_cmd.push_norm  = !i_sts.norm_full;
                            o_cmd.res_status = i_sts.norm_full ? ST_DROPPED : ST_INSERTED;
                        end
                    end else if (i_sts.prio_any) begin
                        o_cmd.pop_prio = 1'b1;
                        n_rd_status    = ST_SERVED_PRIO;
                        n_state        = S_READ;
                    end else if (i_sts.norm_any) begin
                        o_cmd.pop_norm = 1'b1;
                        n_rd_status    = ST_SERVED_NORM;
                        n_state        = S_READ;
                    end else begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_EMPTY;
                    end
                end
            end
            S_READ: begin
                // read data is in the RAM output register now
                o_cmd.res_load     = 1'b1;
                o_cmd.res_from_ram = 1'b1;
                o_cmd.res_status   = r_rd_status;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rd_status <= n_rd_status;
    end

endmodule

// ===== hdl/tcpf_dp.sv =====
// Datapath of the two-class priority FIFO: threshold, queue pointers, stores
// and the output register with its skid stage. Depends on tcpf_pkg, tcpf_ram.
`include "two_class_priority_fifo_top_defines.svh"

module tcpf_dp
    import tcpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int TAG_BITS    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [KEY_W-1:0]     i_cfg_wdata,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [PAYLOAD_W-1:0] i_payload,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [STATUS_W-1:0]  o_out_status,
    output logic [KEY_W-1:0]     o_out_key,
    output logic [PAYLOAD_W-1:0] o_out_payload
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = KEY_W + TAG_BITS;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_res;

    logic [KEY_W-1:0] r_thresh;

    logic [AW-1:0] r_prio_head, r_prio_tail, r_norm_head, r_norm_tail;
    logic [CW-1:0] r_prio_cnt, r_norm_cnt;

    logic [63:0]       w_tag_wide;
    logic [EW-1:0]     w_wentry;
    logic [EW-1:0]     w_prio_rd, w_norm_rd, w_rd_entry;
    logic [63:0]       w_rd_tag_wide;

    t_res w_res;
    t_res r_out, r_skid;
    logic r_out_valid, r_skid_valid;
    logic w_out_free;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // keep the low TAG_BITS of the payload; entry = {key, tag}
    assign w_tag_wide = {32'd0, i_payload};
    assign w_wentry   = {i_key, w_tag_wide[TAG_BITS-1:0]};

    tcpf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push_prio),
        .i_waddr(r_prio_tail),
        .i_wdata(w_wentry),
        .i_re   (i_cmd.pop_prio),
        .i_raddr(r_prio_head),
        .o_rdata(w_prio_rd)
    );

    tcpf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_norm_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push_norm),
        .i_waddr(r_norm_tail),
        .i_wdata(w_wentry),
        .i_re   (i_cmd.pop_norm),
        .i_raddr(r_norm_head),
        .o_rdata(w_norm_rd)
    );

    // pointers and fill counts; push and pop never coincide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_head <= '0;
            r_prio_tail <= '0;
            r_prio_cnt  <= '0;
            r_norm_head <= '0;
            r_norm_tail <= '0;
            r_norm_cnt  <= '0;
        end else begin
            if (i_cmd.push_prio) begin
                r_prio_tail <= (r_prio_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_prio_tail + 1'b1;
                r_prio_cnt  <= r_prio_cnt + 1'b1;
            end else if (i_cmd.pop_prio) begin
                r_prio_head <= (r_prio_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_prio_head + 1'b1;
                r_prio_cnt  <= r_prio_cnt - 1'b1;
            end
            if (i_cmd.push_norm) begin
                r_norm_tail <= (r_norm_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_norm_tail + 1'b1;
                r_norm_cnt  <= r_norm_cnt + 1'b1;
            end else if (i_cmd.pop_norm) begin
                r_norm_head <= (r_norm_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_norm_head + 1'b1;
                r_norm_cnt  <= r_norm_cnt - 1'b1;
            end
        end
    end

    assign o_sts.cls_prio  = (i_key >= r_thresh);
    assign o_sts.prio_full = (r_prio_cnt == CW'(QUEUE_DEPTH));
    assign o_sts.norm_full = (r_norm_cnt == CW'(QUEUE_DEPTH));
    assign o_sts.prio_any  = (r_prio_cnt != '0);
    assign o_sts.norm_any  = (r_norm_cnt != '0);
    assign o_sts.skid_full = r_skid_valid;

    // assemble the result word
    assign w_rd_entry    = (i_cmd.res_status == ST_SERVED_PRIO) ? w_prio_rd : w_norm_rd;
    assign w_rd_tag_wide = 64'(w_rd_entry[TAG_BITS-1:0]);

    always_comb begin
        w_res.status  = i_cmd.res_status;
        w_res.key     = '0;
        w_res.payload = '0;
        if (i_cmd.res_from_ram) begin
            w_res.key     = w_rd_entry[EW-1:TAG_BITS];
            w_res.payload = w_rd_tag_wide[PAYLOAD_W-1:0];
        end
    end

    // output register with one skid entry behind it
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_cmd.res_load;
            end else begin
                r_out_valid  <= i_cmd.res_load;
            end
        end else if (i_cmd.res_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_cmd.res_load) begin
                    r_skid <= w_res;
                end
            end else if (i_cmd.res_load) begin
                r_out <= w_res;
            end
        end else if (i_cmd.res_load) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_status  = r_out.status;
    assign o_out_key     = r_out.key;
    assign o_out_payload = r_out.payload;

    `TCPF_ASSERT_NOW(a_prio_cnt_range, i_clk, i_rst_n, 1'b1, r_prio_cnt <= CW'(QUEUE_DEPTH), "priority count beyond depth")
    `TCPF_ASSERT_NOW(a_norm_cnt_range, i_clk, i_rst_n, 1'b1, r_norm_cnt <= CW'(QUEUE_DEPTH), "normal count beyond depth")
    `TCPF_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop_prio || i_cmd.pop_norm, (i_cmd.pop_prio && r_prio_cnt != '0) || (i_cmd.pop_norm && r_norm_cnt != '0), "pop from empty queue")
    `TCPF_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, i_cmd.res_load, !r_skid_valid, "result loaded while skid entry occupied")
    `TCPF_ASSERT_NEXT(a_pop_then_load, i_clk, i_rst_n, i_cmd.pop_prio || i_cmd.pop_norm, i_cmd.res_load && i_cmd.res_from_ram, "read data not taken after pop")

endmodule
